/* src/mrs_pkg.sv */
// Package for the meter reading scaler: shared types, codes and constants.
// Used by mrs_ctrl, mrs_dpath and meter_reading_scaler; depends on nothing.
package mrs_pkg;

  // Field and datapath widths.
  localparam int MODE_W  = 2;
  localparam int RAW_W   = 24;
  localparam int PER_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int NUM_W   = 26;
  localparam int RES_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 26;
  localparam int DIVD_W  = 40;                  // widest dividend: 24x16 product
  localparam int DIVS_W  = 20;                  // widest divisor: 1000000
  localparam int PWR_W   = 2 * RES_W;
  localparam int DIV_STEPS = DIVD_W;            // one quotient bit per step
  localparam int CNT_W   = $clog2(DIV_STEPS);

  // Divisors and limits.
  localparam logic [DIVS_W-1:0] RMS_DIVISOR   = DIVS_W'(1000000);
  localparam logic [DIVS_W-1:0] POWER_DIVISOR = DIVS_W'(1000);
  localparam logic [RES_W-1:0]  SAT_MAX       = '1;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] VGAIN_RST = GAIN_W'(1169);
  localparam logic [GAIN_W-1:0] CGAIN_RST = GAIN_W'(3546);
  localparam logic [NUM_W-1:0]  FNUM_RST  = NUM_W'(44744312);

  // Conversion modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_FREQ    = 2'd0,
    MODE_VOLTAGE = 2'd1,
    MODE_CURRENT = 2'd2,
    MODE_POWER   = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_VGAIN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CGAIN = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FNUM  = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic load;      // set up dividend and divisor
    logic step;      // one restoring division step
    logic finish;    // clip, post the result, update kept values
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } stat_t;

endpackage

/* src/mrs_ctrl.sv */
// Controller of the meter reading scaler: sequences load, division and finish.
// Depends on mrs_pkg.
module mrs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrs_pkg::stat_t stat,
  output mrs_pkg::cmd_t  cmd
);

  mrs_pkg::state_t             state_r, state_nxt;
  logic [mrs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrs_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      mrs_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = mrs_pkg::ST_LOAD;
        end
      end
      mrs_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = mrs_pkg::ST_DIV;
      end
      mrs_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == mrs_pkg::CNT_W'(mrs_pkg::DIV_STEPS - 1)) begin
          state_nxt = mrs_pkg::ST_FIN;
        end
      end
      mrs_pkg::ST_FIN: begin
        // Hold here while the previous result is still waiting downstream.
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = mrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/mrs_dpath.sv */
// Datapath of the meter reading scaler: configuration registers, multiplier,
// restoring divider, clipping, kept values and output register. Depends on mrs_pkg.
module mrs_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mrs_pkg::cmd_t                 cmd,
  output mrs_pkg::stat_t                stat,
  input  logic                          cfg_we,
  input  logic [mrs_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [mrs_pkg::CDAT_W-1:0]    cfg_data,
  input  logic [mrs_pkg::MODE_W-1:0]    in_mode,
  input  logic [mrs_pkg::RAW_W-1:0]     in_raw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrs_pkg::RES_W-1:0]     out_value,
  output logic                          out_sat
);

  logic [mrs_pkg::GAIN_W-1:0] vgain_r, cgain_r;
  logic [mrs_pkg::NUM_W-1:0]  fnum_r;
  logic [mrs_pkg::RES_W-1:0]  last_volt_r, last_cur_r;
  logic [mrs_pkg::MODE_W-1:0] mode_r;
  logic [mrs_pkg::RAW_W-1:0]  raw_r;
  logic [mrs_pkg::DIVD_W-1:0] dq_r;       // dividend shifting out, quotient in
  logic [mrs_pkg::DIVS_W-1:0] rem_r;
  logic [mrs_pkg::DIVS_W-1:0] div_r;
  logic                       out_valid_r;
  logic [mrs_pkg::RES_W-1:0]  out_value_r;
  logic                       out_sat_r;

  logic [mrs_pkg::GAIN_W-1:0] gain_sel;
  logic [mrs_pkg::DIVD_W-1:0] prod_rms;
  logic [mrs_pkg::PWR_W-1:0]  prod_pwr;
  logic [mrs_pkg::DIVD_W-1:0] dvd_sel;
  logic [mrs_pkg::DIVS_W-1:0] dvs_sel;
  logic [mrs_pkg::DIVS_W:0]   rem_sh;
  logic [mrs_pkg::DIVS_W:0]   rem_sub;
  logic                       q_bit;
  logic                       res_sat;
  logic [mrs_pkg::RES_W-1:0]  res_val;

  assign gain_sel = (mode_r == mrs_pkg::MODE_VOLTAGE) ? vgain_r : cgain_r;
  assign prod_rms = mrs_pkg::DIVD_W'(raw_r) * mrs_pkg::DIVD_W'(gain_sel);
  assign prod_pwr = mrs_pkg::PWR_W'(last_cur_r) * mrs_pkg::PWR_W'(last_volt_r);

  // A zero period leaves the divisor at zero; every step then subtracts
  // nothing and sets its quotient bit, so the result clips on its own.
  always_comb begin
    case (mode_r)
      mrs_pkg::MODE_FREQ: begin
        dvd_sel = mrs_pkg::DIVD_W'(fnum_r);
        dvs_sel = mrs_pkg::DIVS_W'(raw_r[mrs_pkg::PER_W-1:0]);
      end
      mrs_pkg::MODE_VOLTAGE, mrs_pkg::MODE_CURRENT: begin
        dvd_sel = prod_rms;
        dvs_sel = mrs_pkg::RMS_DIVISOR;
      end
      default: begin
        dvd_sel = mrs_pkg::DIVD_W'(prod_pwr);
        dvs_sel = mrs_pkg::POWER_DIVISOR;
      end
    endcase
  end

  assign rem_sh  = {rem_r, dq_r[mrs_pkg::DIVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign q_bit   = (rem_sh >= {1'b0, div_r});

  assign res_sat = |dq_r[mrs_pkg::DIVD_W-1:mrs_pkg::RES_W];
  assign res_val = res_sat ? mrs_pkg::SAT_MAX : dq_r[mrs_pkg::RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vgain_r     <= mrs_pkg::VGAIN_RST;
      cgain_r     <= mrs_pkg::CGAIN_RST;
      fnum_r      <= mrs_pkg::FNUM_RST;
      last_volt_r <= '0;
      last_cur_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mrs_pkg::CFG_VGAIN: vgain_r <= cfg_data[mrs_pkg::GAIN_W-1:0];
          mrs_pkg::CFG_CGAIN: cgain_r <= cfg_data[mrs_pkg::GAIN_W-1:0];
          mrs_pkg::CFG_FNUM:  fnum_r  <= cfg_data[mrs_pkg::NUM_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (mode_r == mrs_pkg::MODE_VOLTAGE) begin
          last_volt_r <= res_val;
        end
        if (mode_r == mrs_pkg::MODE_CURRENT) begin
          last_cur_r <= res_val;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      raw_r  <= in_raw;
    end
    if (cmd.load) begin
      dq_r  <= dvd_sel;
      div_r <= dvs_sel;
      rem_r <= '0;
    end else if (cmd.step) begin
      dq_r  <= {dq_r[mrs_pkg::DIVD_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[mrs_pkg::DIVS_W-1:0] : rem_sh[mrs_pkg::DIVS_W-1:0];
    end
    if (cmd.finish) begin
      out_value_r <= res_val;
      out_sat_r   <= res_sat;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_sat       = out_sat_r;

endmodule

/* src/meter_reading_scaler.sv */
// Meter reading scaler: raw meter readings to frequency, voltage, current, power.
// An input transaction is captured at accept; then come one operand load, the 40
// restoring divider steps and one finish, which raises out_tvalid. No new transaction
// is accepted until the controller is back in idle, and it also holds in the finish
// state while a finished result waits on out_tready. Reset (rst_n low, synchronous): gains
// and numerator to defaults, kept values to zero, controller idle, output empty.
module meter_reading_scaler (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] raw_reading
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] scaled_value
  output logic        out_tuser,  // [0] saturated
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  mrs_pkg::cmd_t  cmd;
  mrs_pkg::stat_t stat;

  // Configuration writes are taken in any cycle; the user must issue them only while
  // no transaction is in flight, as the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  // The controller owns the handshake on the input side and steps the
  // datapath through operand load, the shared divider and the final clip.
  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Every mode is one division: numerator by period, RMS product by one
  // million, or kept current times kept voltage by one thousand. The output
  // register lets the next input transaction start while a result waits.
  mrs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (in_tuser),
    .in_raw    (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_sat   (out_tuser)
  );

endmodule
